// File: src/cascaded_biquad_iir_filter_defines.svh
// ---------------------------------------------------------------------------
// Cascaded biquad IIR filter: assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef CASCADED_BIQUAD_IIR_FILTER_DEFINES_SVH
`define CASCADED_BIQUAD_IIR_FILTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define CBQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent
`define CBQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/cbq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cascaded biquad IIR filter package
// Widths, register codes, sequencing constants and controller/datapath types.
// ---------------------------------------------------------------------------
package cbq_pkg;

   // Sizing
   localparam int MAX_SECTIONS = 8;
   localparam int COEF_WIDTH   = 20;
   localparam int SAMPLE_WIDTH = 16;
   localparam int FRAC_BITS    = 16;
   localparam int HIST_W       = 40;
   localparam int GAIN_RESET   = 1 << FRAC_BITS;   // 1.0 in Q4.16

   // Configuration register widths
   localparam int SEC_REG_W  = 4;
   localparam int SEL_REG_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = COEF_WIDTH;

   // Section and coefficient addressing
   localparam int SEC_IDX_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int SEC_CNT_W  = $clog2(MAX_SECTIONS + 1);
   localparam int COEF_IDX_W = SEC_IDX_W + 2;
   localparam int COEF_DEPTH = 4 * MAX_SECTIONS;

   // Multiplier and accumulator widths
   localparam int HH_W    = HIST_W - FRAC_BITS;
   localparam int MUL_B_W = (HH_W > SAMPLE_WIDTH) ? HH_W : SAMPLE_WIDTH;
   localparam int P_W     = COEF_WIDTH + MUL_B_W;
   localparam int TERM_W  = P_W + 1;
   localparam int ACC_W   = ((HIST_W > P_W) ? HIST_W : P_W) + 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SEC_COUNT  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SEL   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_VALUE = CSR_IDX_W'(3);

   // Per-section step sequence: even steps multiply the low half of a history
   // word, odd steps the high half; accumulation trails by one product.
   localparam int                STEP_W      = 4;
   localparam logic [STEP_W-1:0] STEP_ACC_A1 = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_ACC_A2 = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_ACC_B1 = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(8);

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_GAIN,
      CTL_SECTION,
      CTL_FINISH
   } ctl_state_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_GAIN,
      MUL_LO,
      MUL_HI
   } mul_src_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_GAIN,
      ACC_SUB,
      ACC_SUB_SAT_T,
      ACC_ADD,
      ACC_ADD_SAT_Y
   } acc_op_type;

   typedef struct packed {
      mul_src_type          mul_src;
      logic [1:0]           coef_k;
      acc_op_type           acc_op;
      logic [SEC_IDX_W-1:0] sec;
      logic                 flag_clr;
      logic                 out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [SEC_CNT_W-1:0] n_sections;
   } dp_sts_type;

endpackage

// File: src/cbq_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cascaded biquad datapath
// Configuration registers, coefficient and history storage, one shared
// multiplier, accumulator with 40-bit saturation and the output register.
// ---------------------------------------------------------------------------
module cbq_datapath
   import cbq_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_data,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   input  dp_cmd_type                     cmd,
   output dp_sts_type                     sts,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                           rsp_saturated
);

   logic signed [COEF_WIDTH-1:0]   gain_ff;
   logic [SEC_REG_W-1:0]           sec_count_ff;
   logic [SEL_REG_W-1:0]           coef_sel_ff;
   logic signed [COEF_WIDTH-1:0]   coef_mem [COEF_DEPTH];
   logic signed [HIST_W-1:0]       w0_mem [MAX_SECTIONS];
   logic signed [HIST_W-1:0]       w1_mem [MAX_SECTIONS];

   logic signed [P_W-1:0]          plo_ff;
   logic signed [P_W-1:0]          phi_ff;
   logic signed [ACC_W-1:0]        acc_ff;
   logic signed [ACC_W-1:0]        acc_in;
   logic signed [HIST_W-1:0]       t_ff;
   logic                           flag_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_ff;
   logic                           out_sat_ff;

   logic [COEF_IDX_W-1:0]          coef_addr;
   logic signed [HIST_W-1:0]       hist_rd;
   logic signed [HH_W-1:0]         hist_hi;
   logic [FRAC_BITS-1:0]           hist_lo;
   logic signed [COEF_WIDTH-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]      mul_b;
   logic signed [P_W-1:0]          prod;
   logic signed [TERM_W-1:0]       term;
   logic signed [ACC_W-1:0]        sum_add;
   logic signed [ACC_W-1:0]        sum_sub;
   logic signed [ACC_W-1:0]        sat_src;
   logic signed [HIST_W-1:0]       sat_val;
   logic                           sat_ovf;
   logic                           sat_op;
   logic signed [HIST_W-1:0]       y_hist;
   logic signed [HIST_W-1:0]       y_shift;
   logic signed [SAMPLE_WIDTH-1:0] out_val;
   logic                           out_ovf;

   // Configuration registers and coefficient table
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= COEF_WIDTH'(GAIN_RESET);
         sec_count_ff <= '0;
         coef_sel_ff  <= '0;
         for (int i = 0; i < COEF_DEPTH; i++) begin
            coef_mem[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN:       gain_ff      <= csr_data[COEF_WIDTH-1:0];
            CSR_SEC_COUNT:  sec_count_ff <= csr_data[SEC_REG_W-1:0];
            CSR_COEF_SEL:   coef_sel_ff  <= csr_data[SEL_REG_W-1:0];
            CSR_COEF_VALUE: begin
               // entries past the table are dropped
               if (int'(coef_sel_ff) < COEF_DEPTH) begin
                  coef_mem[COEF_IDX_W'(coef_sel_ff)] <= csr_data[COEF_WIDTH-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   // Sections in use, clamped to the table size
   always_comb begin
      if (int'(sec_count_ff) > MAX_SECTIONS) begin
         sts.n_sections = SEC_CNT_W'(MAX_SECTIONS);
      end else begin
         sts.n_sections = SEC_CNT_W'(sec_count_ff);
      end
   end

   // Operand selection: a1/b1 use w0, a2/b2 use w1
   assign coef_addr = {cmd.sec, cmd.coef_k};
   assign hist_rd   = cmd.coef_k[0] ? w1_mem[cmd.sec] : w0_mem[cmd.sec];
   assign hist_hi   = hist_rd[HIST_W-1:FRAC_BITS];
   assign hist_lo   = hist_rd[FRAC_BITS-1:0];

   always_comb begin
      mul_a = coef_mem[coef_addr];
      mul_b = MUL_B_W'(hist_hi);
      unique case (cmd.mul_src)
         MUL_GAIN: begin
            mul_a = gain_ff;
            mul_b = MUL_B_W'(req_sample_in);
         end
         MUL_LO:   mul_b = MUL_B_W'({1'b0, hist_lo});
         MUL_HI:   mul_b = MUL_B_W'(hist_hi);
         MUL_NONE: mul_b = MUL_B_W'(hist_hi);
         default:  mul_b = MUL_B_W'(hist_hi);
      endcase
   end

   assign prod = mul_a * mul_b;

   // Product registers: low-half partial and high-half (or gain) partial
   always_ff @(posedge clock) begin
      if (cmd.mul_src == MUL_LO) begin
         plo_ff <= prod;
      end
      if (cmd.mul_src == MUL_HI || cmd.mul_src == MUL_GAIN) begin
         phi_ff <= prod;
      end
   end

   // floor(c*h / 2^16) = c*hh + floor(c*hl / 2^16)
   assign term    = TERM_W'(phi_ff) + TERM_W'(plo_ff >>> FRAC_BITS);
   assign sum_add = acc_ff + ACC_W'(term);
   assign sum_sub = acc_ff - ACC_W'(term);

   // Saturation to the 40-bit history format
   always_comb begin
      unique case (cmd.acc_op)
         ACC_LOAD_GAIN:          sat_src = ACC_W'(phi_ff);
         ACC_SUB, ACC_SUB_SAT_T: sat_src = sum_sub;
         ACC_ADD, ACC_ADD_SAT_Y: sat_src = sum_add;
         ACC_HOLD:               sat_src = acc_ff;
         default:                sat_src = acc_ff;
      endcase
      sat_ovf = !((&sat_src[ACC_W-1:HIST_W-1]) || !(|sat_src[ACC_W-1:HIST_W-1]));
      if (sat_ovf) begin
         sat_val = sat_src[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}}
                                    : {1'b0, {(HIST_W-1){1'b1}}};
      end else begin
         sat_val = sat_src[HIST_W-1:0];
      end
      sat_op = (cmd.acc_op == ACC_LOAD_GAIN) || (cmd.acc_op == ACC_SUB_SAT_T) ||
               (cmd.acc_op == ACC_ADD_SAT_Y);
   end

   // Accumulator next value
   always_comb begin
      unique case (cmd.acc_op)
         ACC_SUB:                                     acc_in = sum_sub;
         ACC_ADD:                                     acc_in = sum_add;
         ACC_LOAD_GAIN, ACC_SUB_SAT_T, ACC_ADD_SAT_Y: acc_in = ACC_W'(sat_val);
         ACC_HOLD:                                    acc_in = acc_ff;
         default:                                     acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.acc_op == ACC_SUB_SAT_T) begin
         t_ff <= sat_val;
      end
      if (cmd.flag_clr) begin
         flag_ff <= 1'b0;
      end else if (sat_op && sat_ovf) begin
         flag_ff <= 1'b1;
      end
   end

   // History shift at the end of each section
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SECTIONS; i++) begin
            w0_mem[i] <= '0;
            w1_mem[i] <= '0;
         end
      end else if (cmd.acc_op == ACC_ADD_SAT_Y) begin
         w1_mem[cmd.sec] <= w0_mem[cmd.sec];
         w0_mem[cmd.sec] <= t_ff;
      end
   end

   // Output: floor(y / 2^16), saturated to the sample width
   assign y_hist  = acc_ff[HIST_W-1:0];
   assign y_shift = y_hist >>> FRAC_BITS;

   always_comb begin
      out_ovf = !((&y_shift[HIST_W-1:SAMPLE_WIDTH-1]) ||
                  !(|y_shift[HIST_W-1:SAMPLE_WIDTH-1]));
      if (out_ovf) begin
         out_val = y_shift[HIST_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end else begin
         out_val = y_shift[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff     <= out_val;
         out_sat_ff <= flag_ff | out_ovf;
      end
   end

   assign rsp_sample_out = out_ff;
   assign rsp_saturated  = out_sat_ff;

endmodule

// File: src/cbq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cascaded biquad controller
// Sequences the gain multiply, nine steps per section and the result
// handoff; owns the request ready and the response valid.
// ---------------------------------------------------------------------------
module cbq_ctrl
   import cbq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctl_state_type        state_ff;
   ctl_state_type        state_in;
   logic [SEC_CNT_W-1:0] sec_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 rsp_valid_ff;
   logic                 last_sec;
   logic                 out_free;

   assign last_sec = (sec_ff + SEC_CNT_W'(1)) == sts.n_sections;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               state_in = CTL_GAIN;
            end
         end
         CTL_GAIN: begin
            if (sts.n_sections == '0) begin
               state_in = CTL_FINISH;
            end else begin
               state_in = CTL_SECTION;
            end
         end
         CTL_SECTION: begin
            if (step_ff == STEP_LAST && last_sec) begin
               state_in = CTL_FINISH;
            end
         end
         CTL_FINISH: begin
            if (out_free) begin
               state_in = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   // Outputs and datapath commands
   always_comb begin
      cmd       = '0;
      cmd.sec   = sec_ff[SEC_IDX_W-1:0];
      req_ready = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.mul_src  = MUL_GAIN;
               cmd.flag_clr = 1'b1;
            end
         end
         CTL_GAIN: begin
            cmd.acc_op = ACC_LOAD_GAIN;
         end
         CTL_SECTION: begin
            cmd.coef_k = step_ff[2:1];
            if (step_ff != STEP_LAST) begin
               cmd.mul_src = step_ff[0] ? MUL_HI : MUL_LO;
            end
            unique case (step_ff)
               STEP_ACC_A1: cmd.acc_op = ACC_SUB;
               STEP_ACC_A2: cmd.acc_op = ACC_SUB_SAT_T;
               STEP_ACC_B1: cmd.acc_op = ACC_ADD;
               STEP_LAST:   cmd.acc_op = ACC_ADD_SAT_Y;
               default:     cmd.acc_op = ACC_HOLD;
            endcase
         end
         CTL_FINISH: begin
            cmd.out_load = out_free;
         end
         default: ;
      endcase
   end

   // State, section and step counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
         sec_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == CTL_GAIN) begin
            sec_ff  <= '0;
            step_ff <= '0;
         end else if (state_ff == CTL_SECTION) begin
            if (step_ff == STEP_LAST) begin
               step_ff <= '0;
               sec_ff  <= sec_ff + SEC_CNT_W'(1);
            end else begin
               step_ff <= step_ff + STEP_W'(1);
            end
         end
      end
   end

   // Response valid: set on load, cleared when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/cascaded_biquad_iir_filter.sv
`timescale 1ns / 1ps
// A sample is taken only while the filter is idle, and the work for each
// sample grows with the number of sections in use (clamped to 8). The pace
// is set by the single shared multiplier: each section needs four
// coefficient*history products, each split into two partial products taken
// one after the other, plus a step to close out the section. The finished
// result sits in an output register, so a new sample can be taken while
// the previous result waits on rsp_ready. Configuration writes are taken
// every cycle; keeping them to idle periods is up to the user, as the
// block itself does not enforce it.
// ---------------------------------------------------------------------------
// Cascaded biquad IIR filter, top level
// Gain stage followed by up to eight direct-form-II second-order sections.
// ---------------------------------------------------------------------------
module cascaded_biquad_iir_filter
   import cbq_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                           rsp_saturated,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Register writes are always accepted; csr_ready is tied high
   assign csr_ready = 1'b1;

   cbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cbq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_sample_in  (req_sample_in),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_sample_out (rsp_sample_out),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

// File: src/cbq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cascaded biquad port checker
// Port-level properties of the filter, bound onto the top level.
// ---------------------------------------------------------------------------
`include "cascaded_biquad_iir_filter_defines.svh"

module cbq_checker
   import cbq_pkg::*;
(
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input logic                           rsp_saturated
);

   // One sample in flight: no back-to-back request transactions
   `CBQ_ASSERT_NEXT(a_no_back_to_back, req_valid && req_ready, !req_ready, "request taken while busy")

   // A stalled response keeps its valid and payload
   `CBQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_out) && $stable(rsp_saturated), "stalled response changed")

   // A new response only comes out of a busy period
   `CBQ_ASSERT_SAME(a_rsp_after_work, $rose(rsp_valid), $past(req_ready) == 1'b0, "response without work")

endmodule

bind cascaded_biquad_iir_filter cbq_checker u_checker (.*);
